FILE: rtl/mscrc_pkg.sv
// Shared types, algorithm codes and CRC update functions for the CRC engine.
package mscrc_pkg;

	// Algorithm select codes
	localparam logic [2:0] ALG_NONE  = 3'd0;
	localparam logic [2:0] ALG_CRC8  = 3'd1;
	localparam logic [2:0] ALG_MODBUS = 3'd2;
	localparam logic [2:0] ALG_CCITT = 3'd3;
	localparam logic [2:0] ALG_CRC32 = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_ALGORITHM  = 2'd0;
	localparam logic [1:0] REG_BIG_ENDIAN = 2'd1;

	// Polynomials and seeds
	localparam logic [7:0]  POLY_CRC8   = 8'h07;
	localparam logic [15:0] POLY_MODBUS = 16'hA001;
	localparam logic [15:0] POLY_CCITT  = 16'h1021;
	localparam logic [31:0] POLY_CRC32  = 32'hEDB88320;
	localparam logic [15:0] SEED_16     = 16'hFFFF;
	localparam logic [31:0] SEED_32     = 32'hFFFFFFFF;

	// One finished frame, handed from front to back
	typedef struct packed {
		logic [31:0] value;
		logic        match;
		logic [1:0]  last_idx;   // number of result bytes minus one
		logic        has_bytes;  // low for algorithm none
		logic        big_endian;
	} rec_t;

	function automatic logic [31:0] init_value(input logic [2:0] alg);
		logic [31:0] v;
		begin
			case (alg)
				ALG_MODBUS, ALG_CCITT: v = {16'h0000, SEED_16};
				ALG_CRC32: v = SEED_32;
				default: v = 32'h0000_0000;
			endcase
			return v;
		end
	endfunction

	// One byte through the selected CRC, bitwise form unrolled over eight steps
	function automatic logic [31:0] crc_update(input logic [2:0] alg, input logic [31:0] c,
			input logic [7:0] b);
		logic [7:0]  c8;
		logic [15:0] c16;
		logic [31:0] c32;
		logic [31:0] r;
		begin
			c8  = c[7:0] ^ b;
			c16 = c[15:0];
			c32 = c ^ {24'h000000, b};
			r   = c;
			case (alg)
				ALG_CRC8: begin
					for (int i = 0; i < 8; i++)
						c8 = c8[7] ? ({c8[6:0], 1'b0} ^ POLY_CRC8) : {c8[6:0], 1'b0};
					r = {24'h000000, c8};
				end
				ALG_MODBUS: begin
					c16 = c16 ^ {8'h00, b};
					for (int i = 0; i < 8; i++)
						c16 = c16[0] ? ({1'b0, c16[15:1]} ^ POLY_MODBUS) : {1'b0, c16[15:1]};
					r = {16'h0000, c16};
				end
				ALG_CCITT: begin
					c16 = c16 ^ {b, 8'h00};
					for (int i = 0; i < 8; i++)
						c16 = c16[15] ? ({c16[14:0], 1'b0} ^ POLY_CCITT) : {c16[14:0], 1'b0};
					r = {16'h0000, c16};
				end
				ALG_CRC32: begin
					for (int i = 0; i < 8; i++)
						c32 = c32[0] ? ({1'b0, c32[31:1]} ^ POLY_CRC32) : {1'b0, c32[31:1]};
					r = c32;
				end
				default: r = c;
			endcase
			return r;
		end
	endfunction

endpackage

FILE: rtl/multi_standard_crc_engine.sv
// Multi-standard CRC engine: one byte per cycle in, 0 to 4 result bytes out per frame.
// Input: one item per cycle; its CRC byte update is done in the cycle it is taken; full
// (input stall) is raised only while FIFO_DEPTH finished frames wait on the output side.
// Output: with nothing queued, a frame's first result shows the cycle after its frame end
// is taken; a frame yields 1, 2 or 4 results, one per cycle, paced by pop.
// Reset (arst_n low, asynchronous) clears registers, the queue and the open frame.
module multi_standard_crc_engine #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        frame_end,
	input  logic [31:0] expected_crc,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  crc_byte,
	output logic        byte_valid,
	output logic        last_of_run,
	output logic [31:0] crc_value,
	output logic        crc_match
);

	localparam int REC_W = $bits(mscrc_pkg::rec_t);

	logic [2:0]      alg_q;
	logic            be_q;
	logic            rec_push;
	logic            rec_pop;
	logic            q_empty;
	mscrc_pkg::rec_t rec_in;
	mscrc_pkg::rec_t rec_out;
	logic [REC_W-1:0] rec_out_bits;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q <= mscrc_pkg::ALG_NONE;
			be_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mscrc_pkg::REG_ALGORITHM:  alg_q <= cfg_data;
				mscrc_pkg::REG_BIG_ENDIAN: be_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mscrc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.alg          (alg_q),
		.big_endian   (be_q),
		.take         (push && !full),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.frame_end    (frame_end),
		.expected_crc (expected_crc),
		.rec_push     (rec_push),
		.rec          (rec_in)
	);

	mscrc_fifo #(
		.WIDTH (REC_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.din    (rec_in),
		.pop    (rec_pop),
		.dout   (rec_out_bits),
		.full   (full),
		.empty  (q_empty)
	);

	assign rec_out = mscrc_pkg::rec_t'(rec_out_bits);
	assign empty   = q_empty;

	mscrc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_avail   (!q_empty),
		.rec         (rec_out),
		.take        (pop),
		.rec_pop     (rec_pop),
		.crc_byte    (crc_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.crc_value   (crc_value),
		.crc_match   (crc_match)
	);

`ifndef NO_ASSERTIONS
	// A frame end request, once taken, is visible on the result side in the next cycle
	a_frame_out: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && frame_end |=> !empty)
		else $error("finished frame not queued");

	// Taking a result that is not the last one leaves the rest of the frame waiting
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last_of_run |=> !empty)
		else $error("frame results lost mid-run");

	// A result without a byte is the single, matching, zero result of algorithm none
	a_none_res: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !byte_valid |-> last_of_run && crc_match && (crc_value == 32'h0000_0000))
		else $error("bad result for algorithm none");

	// Within a run, the value and match flag stay fixed across its bytes
	a_run_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last_of_run |=> $stable(crc_value) && $stable(crc_match))
		else $error("frame value changed mid-run");
`endif

endmodule

FILE: rtl/mscrc_front.sv
// Front end: takes frame bytes, keeps the running CRC, queues finished frames.
module mscrc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         alg,
	input  logic               big_endian,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               has_byte,
	input  logic               frame_end,
	input  logic [31:0]        expected_crc,
	output logic               rec_push,
	output mscrc_pkg::rec_t    rec
);

	logic [31:0] crc_q;
	logic        open_q;
	logic [31:0] crc_base;
	logic [31:0] crc_next;

	// Restart at the seed on the first request of a frame
	assign crc_base = open_q ? crc_q : mscrc_pkg::init_value(alg);
	assign crc_next = has_byte ? mscrc_pkg::crc_update(alg, crc_base, data_byte) : crc_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= 32'h0000_0000;
			open_q <= 1'b0;
		end else if (take) begin
			crc_q  <= crc_next;
			open_q <= !frame_end;
		end
	end

	// Finished value, byte count and match for the frame record
	always_comb begin
		rec.big_endian = big_endian;
		rec.has_bytes  = 1'b1;
		unique case (alg)
			mscrc_pkg::ALG_CRC8: begin
				rec.value    = {24'h000000, crc_next[7:0]};
				rec.last_idx = 2'd0;
			end
			mscrc_pkg::ALG_MODBUS, mscrc_pkg::ALG_CCITT: begin
				rec.value    = {16'h0000, crc_next[15:0]};
				rec.last_idx = 2'd1;
			end
			mscrc_pkg::ALG_CRC32: begin
				rec.value    = ~crc_next;
				rec.last_idx = 2'd3;
			end
			default: begin
				rec.value     = 32'h0000_0000;
				rec.last_idx  = 2'd0;
				rec.has_bytes = 1'b0;
			end
		endcase
		rec.match = !rec.has_bytes || (rec.value == expected_crc);
	end

	assign rec_push = take && frame_end;

endmodule

FILE: rtl/mscrc_fifo.sv
// Small flop-based queue between the front and back ends.
module mscrc_fifo #(
	parameter int WIDTH = 37,
	parameter int DEPTH = 4     // power of two, at least 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_q;
	logic [AW:0]      rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[AW-1:0] == rd_q[AW-1:0]) && (wr_q[AW] != rd_q[AW]);
	assign dout  = mem_q[rd_q[AW-1:0]];

	// Pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= rd_q + 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q[AW-1:0]] <= din;
	end

endmodule

FILE: rtl/mscrc_back.sv
// Back end: splits each queued frame record into its result bytes.
module mscrc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rec_avail,
	input  mscrc_pkg::rec_t rec,
	input  logic            take,
	output logic            rec_pop,
	output logic [7:0]      crc_byte,
	output logic            byte_valid,
	output logic            last_of_run,
	output logic [31:0]     crc_value,
	output logic            crc_match
);

	logic [1:0] idx_q;
	logic [1:0] pos;
	logic       last;

	assign last = (idx_q == rec.last_idx);
	assign pos  = rec.big_endian ? (rec.last_idx - idx_q) : idx_q;

	// Byte counter within the current frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= 2'd0;
		else if (take && rec_avail)
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
	end

	// Byte pick
	always_comb begin
		case (pos)
			2'd0: crc_byte = rec.value[7:0];
			2'd1: crc_byte = rec.value[15:8];
			2'd2: crc_byte = rec.value[23:16];
			default: crc_byte = rec.value[31:24];
		endcase
	end

	assign rec_pop     = take && rec_avail && last;
	assign byte_valid  = rec.has_bytes;
	assign last_of_run = last;
	assign crc_value   = rec.value;
	assign crc_match   = rec.match;

endmodule

FILE: verif/testbench.sv
// Self-checking bench for the CRC engine: directed table, random frames, bitwise CRC predictor.
module testbench;

	// Register index slots past the defined ones, and algorithm codes with no CRC behind them
	localparam logic [1:0] REG_SPARE_LO   = 2'd2;
	localparam logic [1:0] REG_SPARE_HI   = 2'd3;
	localparam logic [2:0] ALG_RSVD_FIRST = 3'd5;
	localparam logic [2:0] ALG_RSVD_LAST  = 3'd7;

	localparam int RANDOM_ITEMS  = 290;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 20;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct {
		logic [7:0]  crc_byte;
		logic        byte_valid;
		logic        last_of_run;
		logic [31:0] crc_value;
		logic        crc_match;
	} crc_result_t;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	// One directed step: a register write or a request; tval is used when typed is set
	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [2:0]  cfg;
		logic [7:0]  d;
		logic        h;
		logic        fe;
		logic [31:0] e;
		logic        typed;
		logic [31:0] tval;
	} stim_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic [1:0]  cfg_index    = 2'd0;
	logic [2:0]  cfg_data     = 3'd0;
	logic        push         = 1'b0;
	logic [7:0]  data_byte    = 8'h00;
	logic        has_byte     = 1'b0;
	logic        frame_end    = 1'b0;
	logic [31:0] expected_crc = 32'h0;
	logic        pop          = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  crc_byte;
	logic        byte_valid;
	logic        last_of_run;
	logic [31:0] crc_value;
	logic        crc_match;

	// Predictor state: configuration plus the open frame
	logic [2:0]  pred_alg     = mscrc_pkg::ALG_NONE;
	logic        pred_big     = 1'b0;
	logic [31:0] pred_running = 32'h0;
	logic        pred_open    = 1'b0;

	crc_result_t pending_results[$];
	int          error_count = 0;
	int          cycle_count = 0;
	logic        sender_calm = 1'b0;

	stim_row_t directed_rows [32] = '{
		// algorithm none right after reset, byte has no effect
		'{ROW_ITEM, 2'd0, 3'd0, 8'hFF, 1'b1, 1'b1, 32'h0, 1'b1, 32'h0},
		// unused algorithm code behaves as none
		'{ROW_WRITE, mscrc_pkg::REG_ALGORITHM, ALG_RSVD_FIRST, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0,
			32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h00, 1'b0, 1'b1, 32'hFFFFFFFF, 1'b1, 32'h0},
		// CRC-8: empty frame, zero byte, all-ones byte
		'{ROW_WRITE, mscrc_pkg::REG_ALGORITHM, mscrc_pkg::ALG_CRC8, 8'h00, 1'b0, 1'b0, 32'h0,
			1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h00, 1'b0, 1'b1, 32'h0, 1'b1, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h00, 1'b1, 1'b1, 32'h0, 1'b1, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'hFF, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
		// Modbus: empty frame matches the seed
		'{ROW_WRITE, mscrc_pkg::REG_ALGORITHM, mscrc_pkg::ALG_MODBUS, 8'h00, 1'b0, 1'b0, 32'h0,
			1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h00, 1'b0, 1'b1, 32'h0000FFFF, 1'b1, 32'h0000FFFF},
		// big endian, multi-byte frame
		'{ROW_WRITE, mscrc_pkg::REG_BIG_ENDIAN, 3'd1, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h31, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h32, 1'b1, 1'b0, 32'hFFFFFFFF, 1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h33, 1'b1, 1'b1, 32'hFFFF0000, 1'b0, 32'h0},
		// CCITT: empty frame, then an ignored byte before the real one
		'{ROW_WRITE, mscrc_pkg::REG_ALGORITHM, mscrc_pkg::ALG_CCITT, 8'h00, 1'b0, 1'b0, 32'h0,
			1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h00, 1'b0, 1'b1, 32'h0, 1'b1, 32'h0000FFFF},
		'{ROW_ITEM, 2'd0, 3'd0, 8'hFF, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h00, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
		// CRC-32: empty frame finishes at zero
		'{ROW_WRITE, mscrc_pkg::REG_ALGORITHM, mscrc_pkg::ALG_CRC32, 8'h00, 1'b0, 1'b0, 32'h0,
			1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h00, 1'b0, 1'b1, 32'h0, 1'b1, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'hFF, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b0, 32'h0},
		'{ROW_WRITE, mscrc_pkg::REG_BIG_ENDIAN, 3'd0, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h80, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
		// algorithm switched inside a frame: CRC-32 start, CRC-8 finish
		'{ROW_ITEM, 2'd0, 3'd0, 8'hAA, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_WRITE, mscrc_pkg::REG_ALGORITHM, mscrc_pkg::ALG_CRC8, 8'h00, 1'b0, 1'b0, 32'h0,
			1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h55, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
		// frame opened under an unused code, finished under CCITT
		'{ROW_WRITE, mscrc_pkg::REG_ALGORITHM, ALG_RSVD_LAST, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0,
			32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h12, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_WRITE, mscrc_pkg::REG_ALGORITHM, mscrc_pkg::ALG_CCITT, 8'h00, 1'b0, 1'b0, 32'h0,
			1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h34, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
		// writes to undefined indexes must change nothing
		'{ROW_WRITE, REG_SPARE_LO, 3'd7, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_WRITE, REG_SPARE_HI, 3'd5, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_ITEM, 2'd0, 3'd0, 8'h7F, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0}
	};

	multi_standard_crc_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.frame_end    (frame_end),
		.expected_crc (expected_crc),
		.empty        (empty),
		.pop          (pop),
		.crc_byte     (crc_byte),
		.byte_valid   (byte_valid),
		.last_of_run  (last_of_run),
		.crc_value    (crc_value),
		.crc_match    (crc_match)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] crc_seed(input logic [2:0] alg);
		case (alg)
			mscrc_pkg::ALG_MODBUS, mscrc_pkg::ALG_CCITT: return 32'h0000_FFFF;
			mscrc_pkg::ALG_CRC32:                        return 32'hFFFF_FFFF;
			default:                                     return 32'h0;
		endcase
	endfunction

	// Bit-serial CRC step over one byte; only the low bits of the width are kept
	function automatic logic [31:0] crc_fold_byte(input logic [2:0] alg, input logic [31:0] c,
			input logic [7:0] b);
		logic [31:0] r;
		int          i;
		r = c;
		case (alg)
			mscrc_pkg::ALG_CRC8: begin
				r = {24'h0, c[7:0] ^ b};
				for (i = 0; i < 8; i++)
					r = r[7] ? (((r << 1) ^ 32'h07) & 32'hFF) : ((r << 1) & 32'hFF);
			end
			mscrc_pkg::ALG_MODBUS: begin
				r = {16'h0, c[15:0] ^ {8'h00, b}};
				for (i = 0; i < 8; i++)
					r = r[0] ? ((r >> 1) ^ 32'hA001) : (r >> 1);
			end
			mscrc_pkg::ALG_CCITT: begin
				r = {16'h0, c[15:0] ^ {b, 8'h00}};
				for (i = 0; i < 8; i++)
					r = r[15] ? (((r << 1) ^ 32'h1021) & 32'hFFFF) : ((r << 1) & 32'hFFFF);
			end
			mscrc_pkg::ALG_CRC32: begin
				r = c ^ {24'h0, b};
				for (i = 0; i < 8; i++)
					r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
			end
			default: ;
		endcase
		return r;
	endfunction

	// Running CRC once this request is taken in, from the current predictor state
	function automatic logic [31:0] crc_with_item(input logic [7:0] d, input logic h);
		logic [31:0] c;
		c = pred_open ? pred_running : crc_seed(pred_alg);
		if (h)
			c = crc_fold_byte(pred_alg, c, d);
		return c;
	endfunction

	// Value reported at frame end
	function automatic logic [31:0] crc_as_sent(input logic [2:0] alg, input logic [31:0] c);
		case (alg)
			mscrc_pkg::ALG_CRC8:                         return c & 32'hFF;
			mscrc_pkg::ALG_MODBUS, mscrc_pkg::ALG_CCITT: return c & 32'hFFFF;
			mscrc_pkg::ALG_CRC32:                        return ~c;
			default:                                     return 32'h0;
		endcase
	endfunction

	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return 0;
		if (roll < 9)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [2:0] pick_algorithm();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll >= 18)
			return 3'($urandom_range(ALG_RSVD_FIRST, ALG_RSVD_LAST));
		if (roll >= 16)
			return mscrc_pkg::ALG_NONE;
		case (roll % 4)
			0:       return mscrc_pkg::ALG_CRC8;
			1:       return mscrc_pkg::ALG_MODBUS;
			2:       return mscrc_pkg::ALG_CCITT;
			default: return mscrc_pkg::ALG_CRC32;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Register write, only with nothing in flight
	task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mscrc_pkg::REG_ALGORITHM)
			pred_alg = val;
		else if (idx == mscrc_pkg::REG_BIG_ENDIAN)
			pred_big = val[0];
	endtask

	// One request; push stays high on acceptance so back-to-back requests need no toggle
	task automatic send_item(input logic [7:0] d, input logic h, input logic fe,
			input logic [31:0] e, input logic typed, input logic [31:0] tval);
		int          gap;
		int          n;
		int          k;
		int          pos;
		logic [31:0] c;
		logic [31:0] v;
		crc_result_t res;
		gap = sender_calm ? 0 : idle_cycles();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		data_byte    <= d;
		has_byte     <= h;
		frame_end    <= fe;
		expected_crc <= e;
		@(posedge clk);
		while (full)
			@(posedge clk);

		// accepted: advance the predictor
		c = crc_with_item(d, h);
		pred_running = c;
		pred_open = 1'b1;
		if (fe) begin
			pred_open = 1'b0;
			v = typed ? tval : crc_as_sent(pred_alg, c);
			case (pred_alg)
				mscrc_pkg::ALG_CRC8:                         n = 1;
				mscrc_pkg::ALG_MODBUS, mscrc_pkg::ALG_CCITT: n = 2;
				mscrc_pkg::ALG_CRC32:                        n = 4;
				default:                                     n = 0;
			endcase
			if (n == 0) begin
				res.crc_byte    = 8'h00;
				res.byte_valid  = 1'b0;
				res.last_of_run = 1'b1;
				res.crc_value   = 32'h0;
				res.crc_match   = 1'b1;
				pending_results.push_back(res);
			end else begin
				for (k = 0; k < n; k++) begin
					pos = pred_big ? (n - 1 - k) : k;
					res.crc_byte    = 8'(v >> (8 * pos));
					res.byte_valid  = 1'b1;
					res.last_of_run = (k == n - 1);
					res.crc_value   = v;
					res.crc_match   = (v == e);
					pending_results.push_back(res);
				end
			end
		end
	endtask

	// Result side: random pop stalls, with calm stretches
	initial begin : result_sink
		int          gap;
		int          left_in_mode;
		logic        calm;
		crc_result_t want;
		left_in_mode = 0;
		calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if (left_in_mode == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				left_in_mode = $urandom_range(5, 30);
			end
			left_in_mode--;
			gap = calm ? 0 : idle_cycles();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: crc_byte %h crc_value %h", $time,
					crc_byte, crc_value);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("crc_byte", 32'(want.crc_byte), 32'(crc_byte));
				check_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
				check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
				check_field("crc_value", want.crc_value, crc_value);
				check_field("crc_match", 32'(want.crc_match), 32'(crc_match));
			end
		end
	end

	// Request side: reset, directed table, random frames, drain
	initial begin : stimulus
		int          random_items;
		int          frames;
		int          len;
		int          broken_at;
		int          k;
		logic [7:0]  d;
		logic        h;
		logic [31:0] v;
		logic [31:0] e;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WRITE)
				write_reg(directed_rows[r].idx, directed_rows[r].cfg);
			else
				send_item(directed_rows[r].d, directed_rows[r].h, directed_rows[r].fe,
					directed_rows[r].e, directed_rows[r].typed, directed_rows[r].tval);
		end

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			sender_calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) != 0)
				write_reg(mscrc_pkg::REG_ALGORITHM, pick_algorithm());
			if ($urandom_range(0, 2) == 0)
				write_reg(mscrc_pkg::REG_BIG_ENDIAN, 3'($urandom_range(0, 7)));
			if ($urandom_range(0, 15) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					3'($urandom_range(0, 7)));
			frames = $urandom_range(1, 6);
			repeat (frames) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
				broken_at = (len > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1)
					: -1;
				for (k = 0; k < len; k++) begin
					// algorithm change in the middle of a frame
					if (k == broken_at)
						write_reg(mscrc_pkg::REG_ALGORITHM, pick_algorithm());
					h = ($urandom_range(0, 7) != 0);
					send_item(8'($urandom), h, 1'b0, $urandom, 1'b0, 32'h0);
					random_items++;
				end
				// closing request: expected value right in half the cases, otherwise off
				d = 8'($urandom);
				h = ($urandom_range(0, 4) != 0);
				v = crc_as_sent(pred_alg, crc_with_item(d, h));
				case ($urandom_range(0, 3))
					0, 1:    e = v;
					2:       e = v ^ (32'h1 << $urandom_range(0, 31));
					default: e = $urandom;
				endcase
				send_item(d, h, 1'b1, e, 1'b0, 32'h0);
				random_items++;
			end
		end

		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
